>>> rtl/pts_pkg.sv
// Shared types and codes of the priority task scheduler.
// Depends on nothing; the scheduler and its testbench import it.
`default_nettype none

package pts_pkg;

   // Command codes carried in the kind field
   typedef enum logic [2:0] {
      KIND_FORK   = 3'd0,
      KIND_SWITCH = 3'd1,
      KIND_SLEEP  = 3'd2,
      KIND_WAKEUP = 3'd3,
      KIND_EXIT   = 3'd4,
      KIND_WAIT   = 3'd5
   } kind_type;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_OK       = 3'd0,
      STAT_NO_FREE  = 3'd1,
      STAT_NO_CHILD = 3'd2,
      STAT_BLOCKED  = 3'd3,
      STAT_IDLE     = 3'd4
   } status_type;

   // Life cycle of one task slot
   typedef enum logic [2:0] {
      ST_FREE   = 3'd0,
      ST_READY  = 3'd1,
      ST_SLEEP  = 3'd2,
      ST_ZOMBIE = 3'd3,
      ST_DEAD   = 3'd4
   } slot_state_type;

   // Sequencer steps
   typedef enum logic [4:0] {
      S_IDLE,
      S_FORK,
      S_INS_LOAD,
      S_INS_HEAD,
      S_INS_LINK,
      S_INS_PRIO,
      S_INS_FIX1,
      S_INS_FIX2,
      S_WK_CHECK,
      S_WK_NEXT,
      S_SCH_REQ,
      S_SCH_POP,
      S_SLP_MARK,
      S_SLP_LINK,
      S_EX_MARK,
      S_EX_SCAN,
      S_WT_SCAN,
      S_WT_END,
      S_RESP
   } seq_state_type;

   localparam int unsigned EVENT_W = 16;
   localparam int unsigned EXIT_W  = 16;
   localparam int unsigned PRIO_W  = 8;

endpackage

`default_nettype wire

>>> rtl/pts_if.sv
// Handshake channels of the priority task scheduler: command, result, register write.
// Depends on nothing.
`default_nettype none

interface pts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [14:0] event_id;
   logic [15:0] exit_code;
   modport source (output valid, kind, event_id, exit_code, input ready);
   modport sink (input valid, kind, event_id, exit_code, output ready);
endinterface

interface pts_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [3:0]  pid;
   logic [3:0]  running_pid;
   logic        idle;
   logic [15:0] child_exit;
   modport source (output valid, status, pid, running_pid, idle, child_exit, input ready);
   modport sink (input valid, status, pid, running_pid, idle, child_exit, output ready);
endinterface

interface pts_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] child_priority;
   modport source (output valid, child_priority, input ready);
   modport sink (input valid, child_priority, output ready);
endinterface

`default_nettype wire

>>> rtl/priority_task_scheduler.sv
// Top level of the priority task scheduler: slot table, list pointers and sequencer.
// Depends on pts_pkg and the channel interfaces in pts_if.sv.
//  - req_chan carries one command item (kind, event_id, exit_code). It is taken
//    only when the block is idle; ready stays low while a command is worked on
//    and until its result item has been taken.
//  - rsp_chan gives exactly one result item per command from an output register.
//    The result holds while the receiver stalls; no new command enters meanwhile.
//  - csr_chan writes child_priority at any time (always ready); write it while
//    no command is in flight.
//  - Steps: one sequencer step a cycle, each reading one slot through a shared
//    port. Refused and spare commands give their result the cycle after they are
//    taken. A ready-queue insertion into an empty queue is S_INS_LOAD alone; at the
//    head it adds S_INS_HEAD; further back it walks S_INS_LINK and S_INS_PRIO along
//    the queue, then S_INS_FIX1 and S_INS_FIX2. Exit and wait each scan all NUM_SLOTS
//    slots; a wakeup walks the sleep list one entry a step, plus S_WK_NEXT and one
//    insertion per woken slot. The next command is taken the cycle after the result
//    item leaves.
//  - Reset: slot 0 runs, all other slots are free, queues are empty,
//    child_priority is 1. No clearing pass is needed.
`default_nettype none

module priority_task_scheduler
   import pts_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = 16
) (
   input  wire           clock,
   input  wire           reset,
   pts_req_if.sink       req_chan,
   pts_rsp_if.source     rsp_chan,
   pts_csr_if.sink       csr_chan
);

   localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int unsigned SW = $clog2(NUM_SLOTS + 1);
   localparam logic [SW-1:0] NONE = SW'(NUM_SLOTS);
   localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

   // Slot table
   slot_state_type      state_mem [NUM_SLOTS];
   logic [IW-1:0]       parent_mem [NUM_SLOTS];
   logic [PRIO_W-1:0]   prio_mem [NUM_SLOTS];
   logic [EVENT_W-1:0]  event_mem [NUM_SLOTS];
   logic [EXIT_W-1:0]   exit_mem [NUM_SLOTS];
   logic [SW-1:0]       link_mem [NUM_SLOTS];

   // Sequencer and working registers
   seq_state_type       seq_ff, seq_in;
   logic [2:0]          kind_ff, kind_in;
   logic [EVENT_W-1:0]  wev_ff, wev_in;
   logic [EXIT_W-1:0]   code_ff, code_in;
   status_type          status_ff, status_in;
   logic [IW-1:0]       pid_ff, pid_in;
   logic [EXIT_W-1:0]   cexit_ff, cexit_in;
   logic [IW-1:0]       ins_slot_ff, ins_slot_in;
   logic [PRIO_W-1:0]   ins_prio_ff, ins_prio_in;
   logic [IW-1:0]       ins_cur_ff, ins_cur_in;
   logic [SW-1:0]       ins_nxt_ff, ins_nxt_in;
   seq_state_type       ins_ret_ff, ins_ret_in;
   logic [SW-1:0]       wk_cur_ff, wk_cur_in;
   logic [SW-1:0]       wk_prev_ff, wk_prev_in;
   logic [SW-1:0]       wk_nxt_ff, wk_nxt_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic                found_ff, found_in;
   logic                zfound_ff, zfound_in;
   logic [IW-1:0]       zidx_ff, zidx_in;
   logic [SW-1:0]       ready_head_ff, ready_head_in;
   logic [SW-1:0]       sleep_head_ff, sleep_head_in;
   logic [SW-1:0]       sleep_tail_ff, sleep_tail_in;
   logic [SW-1:0]       free_next_ff, free_next_in;
   logic [IW-1:0]       run_ff, run_in;
   logic                run_valid_ff, run_valid_in;
   logic [PRIO_W-1:0]   child_prio_ff;

   // Shared read port
   logic [IW-1:0]       rd_idx;
   slot_state_type      rd_state;
   logic [IW-1:0]       rd_parent;
   logic [PRIO_W-1:0]   rd_prio;
   logic [EVENT_W-1:0]  rd_event;
   logic [EXIT_W-1:0]   rd_exit;
   logic [SW-1:0]       rd_link;

   // Write ports, one per field
   logic                st_we, par_we, prio_we, ev_we, ex_we, link_we;
   logic [IW-1:0]       st_wa, par_wa, prio_wa, ev_wa, ex_wa, link_wa;
   slot_state_type      st_wd;
   logic [IW-1:0]       par_wd;
   logic [PRIO_W-1:0]   prio_wd;
   logic [EVENT_W-1:0]  ev_wd;
   logic [EXIT_W-1:0]   ex_wd;
   logic [SW-1:0]       link_wd;

   // Decoded conditions
   logic                req_take;
   logic                idle_block;
   logic                ready_empty;
   logic                sleep_empty;
   logic                wk_end;
   logic                wk_match;
   logic                scan_child;
   logic                scan_last;
   logic                ins_first;
   logic                ins_stay;
   logic                requeue;

   assign rd_state  = state_mem[rd_idx];
   assign rd_parent = parent_mem[rd_idx];
   assign rd_prio   = prio_mem[rd_idx];
   assign rd_event  = event_mem[rd_idx];
   assign rd_exit   = exit_mem[rd_idx];
   assign rd_link   = link_mem[rd_idx];

   assign req_take    = req_chan.valid && (seq_ff == S_IDLE);
   assign idle_block  = !run_valid_ff && (req_chan.kind == KIND_FORK
                        || req_chan.kind == KIND_SLEEP || req_chan.kind == KIND_EXIT
                        || req_chan.kind == KIND_WAIT);
   assign ready_empty = ready_head_ff >= NONE;
   assign sleep_empty = (sleep_head_ff >= NONE) || (sleep_tail_ff >= NONE);
   assign wk_end      = wk_cur_ff >= NONE;
   assign wk_match    = rd_event == wev_ff;
   assign scan_child  = (scan_ff != run_ff) && (rd_parent == run_ff)
                        && (rd_state inside {ST_READY, ST_SLEEP, ST_ZOMBIE});
   assign scan_last   = scan_ff == LAST;
   assign ins_first   = ins_prio_ff > rd_prio;
   assign ins_stay    = ins_prio_ff <= rd_prio;
   assign requeue     = run_valid_ff && (rd_state == ST_READY);

   // Read address of the current step
   always_comb begin
      case (seq_ff)
         S_INS_LOAD: rd_idx = ins_slot_ff;
         S_INS_HEAD: rd_idx = ready_head_ff[IW-1:0];
         S_INS_LINK: rd_idx = ins_cur_ff;
         S_INS_PRIO: rd_idx = ins_nxt_ff[IW-1:0];
         S_WK_CHECK: rd_idx = wk_cur_ff[IW-1:0];
         S_SCH_REQ:  rd_idx = run_ff;
         S_SCH_POP:  rd_idx = ready_head_ff[IW-1:0];
         S_EX_MARK:  rd_idx = run_ff;
         S_EX_SCAN:  rd_idx = scan_ff;
         S_WT_SCAN:  rd_idx = scan_ff;
         S_WT_END:   rd_idx = zidx_ff;
         default:    rd_idx = '0;
      endcase
   end

   // Next step of the sequencer
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         S_IDLE: begin
            if (req_take) begin
               if (idle_block) begin
                  seq_in = S_RESP;
               end else begin
                  case (req_chan.kind)
                     KIND_FORK:   seq_in = S_FORK;
                     KIND_SWITCH: seq_in = S_SCH_REQ;
                     KIND_SLEEP:  seq_in = S_SLP_MARK;
                     KIND_WAKEUP: seq_in = S_WK_CHECK;
                     KIND_EXIT:   seq_in = S_EX_MARK;
                     KIND_WAIT:   seq_in = S_WT_SCAN;
                     default:     seq_in = S_RESP;
                  endcase
               end
            end
         end
         S_FORK:     seq_in = (free_next_ff >= NONE) ? S_RESP : S_INS_LOAD;
         S_INS_LOAD: seq_in = ready_empty ? ins_ret_ff : S_INS_HEAD;
         S_INS_HEAD: seq_in = ins_first ? ins_ret_ff : S_INS_LINK;
         S_INS_LINK: seq_in = (rd_link >= NONE) ? S_INS_FIX1 : S_INS_PRIO;
         S_INS_PRIO: seq_in = ins_stay ? S_INS_LINK : S_INS_FIX1;
         S_INS_FIX1: seq_in = S_INS_FIX2;
         S_INS_FIX2: seq_in = ins_ret_ff;
         S_WK_CHECK: begin
            if (wk_end) begin
               seq_in = (kind_ff == KIND_EXIT) ? S_SCH_POP : S_RESP;
            end else if (wk_match) begin
               seq_in = S_INS_LOAD;
            end
         end
         S_WK_NEXT:  seq_in = S_WK_CHECK;
         S_SCH_REQ:  seq_in = requeue ? S_INS_LOAD : S_SCH_POP;
         S_SCH_POP:  seq_in = S_RESP;
         S_SLP_MARK: seq_in = S_SLP_LINK;
         S_SLP_LINK: seq_in = S_SCH_POP;
         S_EX_MARK:  seq_in = S_EX_SCAN;
         S_EX_SCAN:  seq_in = scan_last ? S_WK_CHECK : S_EX_SCAN;
         S_WT_SCAN:  seq_in = scan_last ? S_WT_END : S_WT_SCAN;
         S_WT_END:   seq_in = (!found_ff || zfound_ff) ? S_RESP : S_SLP_MARK;
         S_RESP:     seq_in = rsp_chan.ready ? S_IDLE : S_RESP;
         default:    seq_in = S_IDLE;
      endcase
   end

   // Datapath and table writes of each step
   always_comb begin
      kind_in       = kind_ff;
      wev_in        = wev_ff;
      code_in       = code_ff;
      status_in     = status_ff;
      pid_in        = pid_ff;
      cexit_in      = cexit_ff;
      ins_slot_in   = ins_slot_ff;
      ins_prio_in   = ins_prio_ff;
      ins_cur_in    = ins_cur_ff;
      ins_nxt_in    = ins_nxt_ff;
      ins_ret_in    = ins_ret_ff;
      wk_cur_in     = wk_cur_ff;
      wk_prev_in    = wk_prev_ff;
      wk_nxt_in     = wk_nxt_ff;
      scan_in       = scan_ff;
      found_in      = found_ff;
      zfound_in     = zfound_ff;
      zidx_in       = zidx_ff;
      ready_head_in = ready_head_ff;
      sleep_head_in = sleep_head_ff;
      sleep_tail_in = sleep_tail_ff;
      free_next_in  = free_next_ff;
      run_in        = run_ff;
      run_valid_in  = run_valid_ff;
      st_we   = 1'b0;  st_wa   = '0;  st_wd   = ST_FREE;
      par_we  = 1'b0;  par_wa  = '0;  par_wd  = '0;
      prio_we = 1'b0;  prio_wa = '0;  prio_wd = '0;
      ev_we   = 1'b0;  ev_wa   = '0;  ev_wd   = '0;
      ex_we   = 1'b0;  ex_wa   = '0;  ex_wd   = '0;
      link_we = 1'b0;  link_wa = '0;  link_wd = NONE;
      case (seq_ff)
         S_IDLE: begin
            // capture the command and clear the result
            if (req_take) begin
               kind_in    = req_chan.kind;
               wev_in     = {1'b0, req_chan.event_id};
               code_in    = req_chan.exit_code;
               status_in  = idle_block ? STAT_IDLE : STAT_OK;
               pid_in     = '0;
               cexit_in   = '0;
               wk_cur_in  = sleep_head_ff;
               wk_prev_in = NONE;
               scan_in    = '0;
               found_in   = 1'b0;
               zfound_in  = 1'b0;
            end
         end
         S_FORK: begin
            // hand out the next unused slot
            if (free_next_ff >= NONE) begin
               status_in = STAT_NO_FREE;
            end else begin
               st_we = 1'b1;   st_wa = free_next_ff[IW-1:0];   st_wd = ST_READY;
               par_we = 1'b1;  par_wa = free_next_ff[IW-1:0];  par_wd = run_ff;
               prio_we = 1'b1; prio_wa = free_next_ff[IW-1:0]; prio_wd = child_prio_ff;
               ev_we = 1'b1;   ev_wa = free_next_ff[IW-1:0];   ev_wd = '0;
               ex_we = 1'b1;   ex_wa = free_next_ff[IW-1:0];   ex_wd = '0;
               free_next_in = free_next_ff + SW'(1);
               pid_in       = free_next_ff[IW-1:0];
               ins_slot_in  = free_next_ff[IW-1:0];
               ins_ret_in   = S_RESP;
            end
         end
         S_INS_LOAD: begin
            // load the priority; empty queue takes the slot as head
            ins_prio_in = rd_prio;
            if (ready_empty) begin
               link_we = 1'b1; link_wa = ins_slot_ff; link_wd = NONE;
               ready_head_in = SW'(ins_slot_ff);
            end
         end
         S_INS_HEAD: begin
            if (ins_first) begin
               link_we = 1'b1; link_wa = ins_slot_ff; link_wd = ready_head_ff;
               ready_head_in = SW'(ins_slot_ff);
            end else begin
               ins_cur_in = ready_head_ff[IW-1:0];
            end
         end
         S_INS_LINK: ins_nxt_in = rd_link;
         S_INS_PRIO: begin
            // advance past entries of equal or higher priority
            if (ins_stay) ins_cur_in = ins_nxt_ff[IW-1:0];
         end
         S_INS_FIX1: begin
            link_we = 1'b1; link_wa = ins_slot_ff;
            link_wd = (ins_nxt_ff >= NONE) ? NONE : ins_nxt_ff;
         end
         S_INS_FIX2: begin
            link_we = 1'b1; link_wa = ins_cur_ff; link_wd = SW'(ins_slot_ff);
         end
         S_WK_CHECK: begin
            if (wk_end) begin
               if (sleep_head_ff >= NONE) begin
                  sleep_head_in = NONE;
                  sleep_tail_in = NONE;
               end
            end else if (wk_match) begin
               // unlink the sleeper and make it ready
               wk_nxt_in = rd_link;
               if (wk_prev_ff < NONE) begin
                  link_we = 1'b1; link_wa = wk_prev_ff[IW-1:0]; link_wd = rd_link;
               end else begin
                  sleep_head_in = rd_link;
               end
               if (sleep_tail_ff == wk_cur_ff) sleep_tail_in = wk_prev_ff;
               st_we = 1'b1; st_wa = wk_cur_ff[IW-1:0]; st_wd = ST_READY;
               ins_slot_in = wk_cur_ff[IW-1:0];
               ins_ret_in  = S_WK_NEXT;
            end else begin
               wk_prev_in = wk_cur_ff;
               wk_cur_in  = rd_link;
            end
         end
         S_WK_NEXT: wk_cur_in = wk_nxt_ff;
         S_SCH_REQ: begin
            if (requeue) begin
               ins_slot_in = run_ff;
               ins_ret_in  = S_SCH_POP;
            end
         end
         S_SCH_POP: begin
            // take the head of the ready queue or go idle
            if (ready_empty) begin
               ready_head_in = NONE;
               run_valid_in  = 1'b0;
               if (kind_ff != KIND_WAIT) status_in = STAT_IDLE;
            end else begin
               run_in        = ready_head_ff[IW-1:0];
               ready_head_in = (rd_link >= NONE) ? NONE : rd_link;
               run_valid_in  = 1'b1;
            end
         end
         S_SLP_MARK: begin
            ev_we = 1'b1;   ev_wa = run_ff;   ev_wd = wev_ff;
            st_we = 1'b1;   st_wa = run_ff;   st_wd = ST_SLEEP;
            link_we = 1'b1; link_wa = run_ff; link_wd = NONE;
         end
         S_SLP_LINK: begin
            // append the running slot to the sleep list
            if (sleep_empty) begin
               sleep_head_in = SW'(run_ff);
            end else begin
               link_we = 1'b1; link_wa = sleep_tail_ff[IW-1:0]; link_wd = SW'(run_ff);
            end
            sleep_tail_in = SW'(run_ff);
         end
         S_EX_MARK: begin
            ex_we = 1'b1; ex_wa = run_ff; ex_wd = code_ff;
            st_we = 1'b1; st_wa = run_ff; st_wd = ST_ZOMBIE;
            wev_in  = {1'b1, 15'(rd_parent)};
            scan_in = '0;
         end
         S_EX_SCAN: begin
            // reparent children to slot 1
            if (scan_child) begin
               par_we = 1'b1; par_wa = scan_ff; par_wd = IW'(1);
            end
            scan_in = scan_ff + IW'(1);
            if (scan_last) begin
               wk_cur_in  = sleep_head_ff;
               wk_prev_in = NONE;
            end
         end
         S_WT_SCAN: begin
            // note children and the lowest zombie child
            if (scan_child) begin
               found_in = 1'b1;
               if (rd_state == ST_ZOMBIE && !zfound_ff) begin
                  zfound_in = 1'b1;
                  zidx_in   = scan_ff;
               end
            end
            scan_in = scan_ff + IW'(1);
         end
         S_WT_END: begin
            if (!found_ff) begin
               status_in = STAT_NO_CHILD;
            end else if (zfound_ff) begin
               st_we = 1'b1; st_wa = zidx_ff; st_wd = ST_DEAD;
               pid_in   = zidx_ff;
               cexit_in = rd_exit;
            end else begin
               wev_in    = {1'b1, 15'(run_ff)};
               status_in = STAT_BLOCKED;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= S_IDLE;
         ready_head_ff <= NONE;
         sleep_head_ff <= NONE;
         sleep_tail_ff <= NONE;
         free_next_ff  <= SW'(1);
         run_ff        <= '0;
         run_valid_ff  <= 1'b1;
         child_prio_ff <= PRIO_W'(1);
      end else begin
         seq_ff        <= seq_in;
         ready_head_ff <= ready_head_in;
         sleep_head_ff <= sleep_head_in;
         sleep_tail_ff <= sleep_tail_in;
         free_next_ff  <= free_next_in;
         run_ff        <= run_in;
         run_valid_ff  <= run_valid_in;
         if (csr_chan.valid) child_prio_ff <= csr_chan.child_priority;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      wev_ff      <= wev_in;
      code_ff     <= code_in;
      status_ff   <= status_in;
      pid_ff      <= pid_in;
      cexit_ff    <= cexit_in;
      ins_slot_ff <= ins_slot_in;
      ins_prio_ff <= ins_prio_in;
      ins_cur_ff  <= ins_cur_in;
      ins_nxt_ff  <= ins_nxt_in;
      ins_ret_ff  <= ins_ret_in;
      wk_cur_ff   <= wk_cur_in;
      wk_prev_ff  <= wk_prev_in;
      wk_nxt_ff   <= wk_nxt_in;
      scan_ff     <= scan_in;
      found_ff    <= found_in;
      zfound_ff   <= zfound_in;
      zidx_ff     <= zidx_in;
   end

   // Slot table with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            state_mem[i]  <= (i == 0) ? ST_READY : ST_FREE;
            parent_mem[i] <= '0;
            prio_mem[i]   <= (i == 0) ? PRIO_W'(0) : PRIO_W'(1);
            event_mem[i]  <= '0;
            exit_mem[i]   <= '0;
         end
      end else begin
         if (st_we)   state_mem[st_wa]   <= st_wd;
         if (par_we)  parent_mem[par_wa] <= par_wd;
         if (prio_we) prio_mem[prio_wa]  <= prio_wd;
         if (ev_we)   event_mem[ev_wa]   <= ev_wd;
         if (ex_we)   exit_mem[ex_wa]    <= ex_wd;
      end
   end

   // List links, always written before read
   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_wa] <= link_wd;
   end

   // Channel outputs
   assign req_chan.ready       = (seq_ff == S_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = (seq_ff == S_RESP);
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.pid         = 4'(pid_ff);
   assign rsp_chan.running_pid = run_valid_ff ? 4'(run_ff) : 4'd0;
   assign rsp_chan.idle        = !run_valid_ff;
   assign rsp_chan.child_exit  = cexit_ff;

endmodule

`default_nettype wire

>>> verif/priority_task_scheduler_test.sv
// Self-checking testbench of the priority task scheduler: directed table, then random commands.
// Depends on pts_pkg, the channel interfaces in pts_if.sv and priority_task_scheduler.
`timescale 1ns / 1ps

module priority_task_scheduler_test;
   import pts_pkg::*;

   localparam int unsigned SLOTS     = 16;
   localparam logic [4:0]  NO_SLOT   = 5'd16;
   localparam logic [15:0] WAIT_FLAG = 16'h8000;
   localparam logic [2:0]  KIND_SPARE6 = 3'd6;
   localparam logic [2:0]  KIND_SPARE7 = 3'd7;
   localparam int unsigned SETTLE_CYCLES = 120;
   localparam int unsigned PHASE_ITEMS   = 200;
   localparam int unsigned PHASE_COUNT   = 7;

   typedef struct packed {
      status_type  status;
      logic [3:0]  pid;
      logic [3:0]  running_pid;
      logic        idle;
      logic [15:0] child_exit;
   } outcome_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [14:0] event_id;
      logic [15:0] exit_code;
      logic        typed;
      outcome_type want;
   } plan_row_type;

   logic clock;
   logic reset;

   pts_req_if req_bus ();
   pts_rsp_if rsp_bus ();
   pts_csr_if csr_bus ();

   priority_task_scheduler #(.NUM_SLOTS(SLOTS)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source),
      .csr_chan (csr_bus.sink)
   );

   // Scheduler state mirror
   slot_state_type tsk_state [SLOTS];
   logic [3:0]     tsk_parent [SLOTS];
   logic [7:0]     tsk_prio [SLOTS];
   logic [15:0]    tsk_event [SLOTS];
   logic [15:0]    tsk_exit [SLOTS];
   logic [4:0]     tsk_link [SLOTS];
   logic [4:0]     ready_first, sleep_first, sleep_last, next_unused;
   logic [3:0]     cur_task;
   logic           cur_valid;
   logic [7:0]     fork_prio;

   outcome_type pending_results [$];
   int unsigned mismatches;
   int unsigned cmds_sent;

   // Clock and the single reset
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Run limit
   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   function automatic bit idle_roll(int unsigned count);
      // quiet stretch with no idling at all
      if (count >= 600 && count < 800) return 1'b0;
      return $urandom_range(99) < 26;
   endfunction

   function automatic void mirror_reset();
      for (int i = 0; i < SLOTS; i++) begin
         tsk_state[i]  = ST_FREE;
         tsk_parent[i] = '0;
         tsk_prio[i]   = 8'd1;
         tsk_event[i]  = '0;
         tsk_exit[i]   = '0;
         tsk_link[i]   = NO_SLOT;
      end
      tsk_state[0] = ST_READY;
      tsk_prio[0]  = 8'd0;
      fork_prio    = 8'd1;
      ready_first  = NO_SLOT;
      sleep_first  = NO_SLOT;
      sleep_last   = NO_SLOT;
      next_unused  = 5'd1;
      cur_task     = '0;
      cur_valid    = 1'b1;
   endfunction

   // Insert behind every entry of equal or higher priority
   function automatic void enqueue_ready(logic [4:0] s);
      logic [4:0] cur, nxt;
      if (s >= NO_SLOT) return;
      if (ready_first >= NO_SLOT || tsk_prio[s] > tsk_prio[ready_first]) begin
         tsk_link[s] = ready_first;
         ready_first = s;
         return;
      end
      cur = ready_first;
      nxt = tsk_link[cur];
      for (int g = 0; g < SLOTS && nxt < NO_SLOT && tsk_prio[s] <= tsk_prio[nxt]; g++) begin
         cur = nxt;
         nxt = tsk_link[cur];
      end
      tsk_link[s]   = (nxt < NO_SLOT) ? nxt : NO_SLOT;
      tsk_link[cur] = s;
   endfunction

   function automatic void wake_sleepers(logic [15:0] ev);
      logic [4:0] cur, prev, nxt;
      cur  = sleep_first;
      prev = NO_SLOT;
      for (int g = 0; g < SLOTS && cur < NO_SLOT; g++) begin
         nxt = tsk_link[cur];
         if (tsk_event[cur] == ev) begin
            if (prev < NO_SLOT) tsk_link[prev] = nxt;
            else sleep_first = nxt;
            if (sleep_last == cur) sleep_last = prev;
            tsk_state[cur] = ST_READY;
            enqueue_ready(cur);
         end else begin
            prev = cur;
         end
         cur = nxt;
      end
      if (sleep_first >= NO_SLOT) begin
         sleep_first = NO_SLOT;
         sleep_last  = NO_SLOT;
      end
   endfunction

   function automatic void park_current(logic [15:0] ev);
      tsk_event[cur_task] = ev;
      tsk_state[cur_task] = ST_SLEEP;
      tsk_link[cur_task]  = NO_SLOT;
      if (sleep_first >= NO_SLOT || sleep_last >= NO_SLOT) sleep_first = {1'b0, cur_task};
      else tsk_link[sleep_last] = {1'b0, cur_task};
      sleep_last = {1'b0, cur_task};
   endfunction

   function automatic bit dispatch(bit requeue);
      if (requeue && cur_valid && tsk_state[cur_task] == ST_READY)
         enqueue_ready({1'b0, cur_task});
      if (ready_first >= NO_SLOT) begin
         ready_first = NO_SLOT;
         cur_valid   = 1'b0;
         return 1'b0;
      end
      cur_task    = ready_first[3:0];
      ready_first = tsk_link[ready_first];
      if (ready_first >= NO_SLOT) ready_first = NO_SLOT;
      cur_valid = 1'b1;
      return 1'b1;
   endfunction

   function automatic bit child_of_current(int i);
      return i != cur_task && tsk_parent[i] == cur_task &&
         (tsk_state[i] == ST_READY || tsk_state[i] == ST_SLEEP || tsk_state[i] == ST_ZOMBIE);
   endfunction

   // Work out the result of one command and advance the mirror
   function automatic outcome_type run_command(logic [2:0] kind, logic [14:0] ev,
                                               logic [15:0] code);
      outcome_type res;
      logic [4:0]  s;
      int          kids, found;
      res = '0;
      res.status = STAT_OK;
      if (!cur_valid && (kind == KIND_FORK || kind == KIND_SLEEP ||
                         kind == KIND_EXIT || kind == KIND_WAIT)) begin
         res.status = STAT_IDLE;
      end else if (kind == KIND_FORK) begin
         if (next_unused >= NO_SLOT) begin
            res.status = STAT_NO_FREE;
         end else begin
            s = next_unused;
            next_unused = next_unused + 5'd1;
            tsk_parent[s] = cur_task;
            tsk_state[s]  = ST_READY;
            tsk_prio[s]   = fork_prio;
            tsk_event[s]  = '0;
            tsk_exit[s]   = '0;
            enqueue_ready(s);
            res.pid = s[3:0];
         end
      end else if (kind == KIND_SWITCH) begin
         if (!dispatch(1'b1)) res.status = STAT_IDLE;
      end else if (kind == KIND_SLEEP) begin
         park_current({1'b0, ev});
         if (!dispatch(1'b0)) res.status = STAT_IDLE;
      end else if (kind == KIND_WAKEUP) begin
         wake_sleepers({1'b0, ev});
      end else if (kind == KIND_EXIT) begin
         tsk_exit[cur_task]  = code;
         tsk_state[cur_task] = ST_ZOMBIE;
         for (int i = 0; i < SLOTS; i++)
            if (child_of_current(i)) tsk_parent[i] = 4'd1;
         wake_sleepers(WAIT_FLAG | {12'd0, tsk_parent[cur_task]});
         if (!dispatch(1'b0)) res.status = STAT_IDLE;
      end else if (kind == KIND_WAIT) begin
         kids  = 0;
         found = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (child_of_current(i)) begin
               kids++;
               if (found < 0 && tsk_state[i] == ST_ZOMBIE) found = i;
            end
         end
         if (kids == 0) begin
            res.status = STAT_NO_CHILD;
         end else if (found >= 0) begin
            tsk_state[found] = ST_DEAD;
            res.pid        = found[3:0];
            res.child_exit = tsk_exit[found];
         end else begin
            park_current(WAIT_FLAG | {12'd0, cur_task});
            void'(dispatch(1'b0));
            res.status = STAT_BLOCKED;
         end
      end
      res.running_pid = cur_valid ? cur_task : 4'd0;
      res.idle        = !cur_valid;
      return res;
   endfunction

   // Offer one command; predict it at the edge that takes it
   task automatic issue_command(logic [2:0] kind, logic [14:0] ev, logic [15:0] code,
                                bit typed, outcome_type want);
      outcome_type exp;
      while (idle_roll(cmds_sent)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.event_id  <= ev;
      req_bus.exit_code <= code;
      do @(posedge clock); while (!req_bus.ready);
      exp = run_command(kind, ev, code);
      pending_results.push_back(typed ? want : exp);
      cmds_sent++;
   endtask

   // Drain, let the block settle, then write the register
   task automatic write_child_priority(logic [7:0] value);
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_bus.valid          <= 1'b1;
      csr_bus.child_priority <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      fork_prio = value;
   endtask

   function automatic logic [14:0] pick_event();
      case ($urandom_range(5))
         0: return 15'd0;
         1: return 15'h7FFF;
         2, 3: return 15'($urandom_range(3));
         default: return 15'($urandom);
      endcase
   endfunction

   function automatic logic [2:0] pick_kind();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 6) return KIND_FORK;
      if (r < 34) return KIND_SWITCH;
      if (r < 50) return KIND_SLEEP;
      if (r < 72) return KIND_WAKEUP;
      if (r < 79) return KIND_EXIT;
      if (r < 96) return KIND_WAIT;
      return r[0] ? KIND_SPARE6 : KIND_SPARE7;
   endfunction

   // Directed part: results typed in where plain from reset
   plan_row_type plan [22] = '{
      '{KIND_WAIT,   15'd0,      16'd0,      1'b1, '{STAT_NO_CHILD, 4'd0, 4'd0, 1'b0, 16'd0}},
      '{KIND_SPARE6, 15'h7FFF,   16'hFFFF,   1'b1, '{STAT_OK, 4'd0, 4'd0, 1'b0, 16'd0}},
      '{KIND_SPARE7, 15'd0,      16'd0,      1'b1, '{STAT_OK, 4'd0, 4'd0, 1'b0, 16'd0}},
      '{KIND_FORK,   15'd0,      16'd0,      1'b1, '{STAT_OK, 4'd1, 4'd0, 1'b0, 16'd0}},
      '{KIND_FORK,   15'd0,      16'd0,      1'b1, '{STAT_OK, 4'd2, 4'd0, 1'b0, 16'd0}},
      '{KIND_SWITCH, 15'd0,      16'd0,      1'b0, '0},
      '{KIND_FORK,   15'd0,      16'd0,      1'b0, '0},
      '{KIND_WAIT,   15'd0,      16'd0,      1'b0, '0},
      '{KIND_WAKEUP, 15'd1,      16'd0,      1'b0, '0},
      '{KIND_SWITCH, 15'd0,      16'd0,      1'b0, '0},
      '{KIND_EXIT,   15'd0,      16'hFFFF,   1'b0, '0},
      '{KIND_SLEEP,  15'h7FFF,   16'd0,      1'b0, '0},
      '{KIND_WAKEUP, 15'h7FFF,   16'd0,      1'b0, '0},
      '{KIND_WAIT,   15'd0,      16'd0,      1'b0, '0},
      '{KIND_SLEEP,  15'd0,      16'd0,      1'b0, '0},
      '{KIND_SWITCH, 15'd0,      16'd0,      1'b0, '0},
      '{KIND_EXIT,   15'd0,      16'd0,      1'b0, '0},
      '{KIND_SWITCH, 15'd0,      16'd0,      1'b0, '0},
      '{KIND_WAKEUP, 15'd0,      16'd0,      1'b0, '0},
      '{KIND_WAIT,   15'd0,      16'd0,      1'b0, '0},
      '{KIND_EXIT,   15'd0,      16'hA5A5,   1'b0, '0},
      '{KIND_SWITCH, 15'd0,      16'd0,      1'b0, '0}
   };

   // Command sender
   initial begin
      logic [7:0] phase_prio [PHASE_COUNT];
      phase_prio = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd2, 8'd77};
      mismatches = 0;
      cmds_sent  = 0;
      mirror_reset();
      req_bus.valid          = 1'b0;
      req_bus.kind           = KIND_FORK;
      req_bus.event_id       = '0;
      req_bus.exit_code      = '0;
      csr_bus.valid          = 1'b0;
      csr_bus.child_priority = '0;
      @(negedge reset);
      @(posedge clock);
      foreach (plan[i])
         issue_command(plan[i].kind, plan[i].event_id, plan[i].exit_code,
                       plan[i].typed, plan[i].want);
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_child_priority(p == PHASE_COUNT - 1 ? 8'($urandom) : phase_prio[p]);
         for (int n = 0; n < PHASE_ITEMS; n++)
            issue_command(pick_kind(), pick_event(),
                          $urandom_range(7) == 0 ? 16'hFFFF : 16'($urandom), 1'b0, '0);
      end
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Result receiver: random stalls, one long hold-off, a quiet stretch
   initial begin
      int unsigned taken;
      bit          held;
      taken = 0;
      held  = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) taken++;
         if (!held && taken >= 300) begin
            held = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_bus.ready <= !reset && !idle_roll(taken);
      end
   end

   // Compare each result item with the oldest expectation
   always @(posedge clock) begin
      outcome_type exp;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result item: status %0d pid %0d",
                        rsp_bus.status, rsp_bus.pid);
         end else begin
            exp = pending_results.pop_front();
            if (rsp_bus.status !== exp.status || rsp_bus.pid !== exp.pid ||
                rsp_bus.running_pid !== exp.running_pid || rsp_bus.idle !== exp.idle ||
                rsp_bus.child_exit !== exp.child_exit) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"result mismatch: exp st %0d pid %0d run %0d idle %0d exit %h,",
                            " got st %0d pid %0d run %0d idle %0d exit %h"},
                           exp.status, exp.pid, exp.running_pid, exp.idle, exp.child_exit,
                           rsp_bus.status, rsp_bus.pid, rsp_bus.running_pid, rsp_bus.idle,
                           rsp_bus.child_exit);
            end
         end
      end
   end

endmodule
